// ===== hdl/calu_pkg.sv =====
package calu_pkg;

    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned IN_USER_W  = 5;
    localparam int unsigned OUT_DATA_W = 32;
    localparam int unsigned OUT_USER_W = 1;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_XOR   = 5'd5,
        OP_OR    = 5'd6,
        OP_CP    = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_RLCA  = 5'd10,
        OP_RRCA  = 5'd11,
        OP_RLA   = 5'd12,
        OP_RRA   = 5'd13,
        OP_DAA   = 5'd14,
        OP_CPL   = 5'd15,
        OP_SCF   = 5'd16,
        OP_CCF   = 5'd17,
        OP_RLC   = 5'd18,
        OP_RRC   = 5'd19,
        OP_RL    = 5'd20,
        OP_RR    = 5'd21,
        OP_SLA   = 5'd22,
        OP_SRA   = 5'd23,
        OP_SWAP  = 5'd24,
        OP_SRL   = 5'd25,
        OP_ADD16 = 5'd26,
        OP_INC16 = 5'd27,
        OP_DEC16 = 5'd28
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  acc;
        logic [7:0]  operand;
        logic [15:0] wide_base;
        logic [15:0] wide_addend;
        logic [3:0]  flags_in;
    } t_alu_in;

    typedef struct packed {
        logic [7:0]  result_byte;
        logic [15:0] result_wide;
        logic [3:0]  flags_out;
        logic        write_back;
    } t_alu_out;

endpackage

// ===== hdl/calu_core.sv =====
module calu_core
    import calu_pkg::*;
(
    input  t_alu_in  i_in,
    output t_alu_out o_out
);

    always_comb begin
        logic [7:0]  a;
        logic [7:0]  v;
        logic [3:0]  f;
        logic        cin;
        logic        zin;
        logic [8:0]  sum9;
        logic [4:0]  sum5;
        logic [8:0]  dif9;
        logic [4:0]  dif5;
        logic [16:0] sum17;
        logic [12:0] sum13;
        logic [7:0]  adj;
        logic        dc;
        logic [7:0]  rb;
        logic [15:0] rw;
        logic [3:0]  fo;
        logic        wr;

        a   = i_in.acc;
        v   = i_in.operand;
        f   = i_in.flags_in;
        cin = f[FLAG_C];
        zin = f[FLAG_Z];

        sum9  = {1'b0, a} + {1'b0, v} + {8'd0, cin & (i_in.op == OP_ADC)};
        sum5  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin & (i_in.op == OP_ADC)};
        dif9  = {1'b0, a} - {1'b0, v} - {8'd0, cin & (i_in.op == OP_SBC)};
        dif5  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin & (i_in.op == OP_SBC)};
        sum17 = {1'b0, i_in.wide_base} + {1'b0, i_in.wide_addend};
        sum13 = {1'b0, i_in.wide_base[11:0]} + {1'b0, i_in.wide_addend[11:0]};

        adj = 8'h00;
        dc  = 1'b0;
        if (f[FLAG_N]) begin
            if (f[FLAG_H]) adj = adj + 8'h06;
            if (cin) adj = adj + 8'h60;
            dc = cin;
        end else begin
            if (f[FLAG_H] || (a[3:0] > 4'h9)) adj = adj + 8'h06;
            if (cin || (a > 8'h99)) begin
                adj = adj + 8'h60;
                dc  = 1'b1;
            end
        end

        rb = 8'h00;
        rw = 16'h0000;
        fo = f;
        wr = 1'b1;

        unique case (i_in.op)
            OP_ADD, OP_ADC: begin
                rb = sum9[7:0];
                fo = {rb == 8'h00, 1'b0, sum5[4], sum9[8]};
            end
            OP_SUB, OP_SBC, OP_CP: begin
                rb = dif9[7:0];
                fo = {rb == 8'h00, 1'b1, dif5[4], dif9[8]};
                wr = (i_in.op != OP_CP);
            end
            OP_AND: begin
                rb = a & v;
                fo = {rb == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            OP_XOR: begin
                rb = a ^ v;
                fo = {rb == 8'h00, 3'b000};
            end
            OP_OR: begin
                rb = a | v;
                fo = {rb == 8'h00, 3'b000};
            end
            OP_INC: begin
                rb = v + 8'd1;
                fo = {rb == 8'h00, 1'b0, v[3:0] == 4'hF, cin};
            end
            OP_DEC: begin
                rb = v - 8'd1;
                fo = {rb == 8'h00, 1'b1, v[3:0] == 4'h0, cin};
            end
            OP_RLCA: begin
                rb = {a[6:0], a[7]};
                fo = {3'b000, a[7]};
            end
            OP_RRCA: begin
                rb = {a[0], a[7:1]};
                fo = {3'b000, a[0]};
            end
            OP_RLA: begin
                rb = {a[6:0], cin};
                fo = {3'b000, a[7]};
            end
            OP_RRA: begin
                rb = {cin, a[7:1]};
                fo = {3'b000, a[0]};
            end
            OP_DAA: begin
                rb = f[FLAG_N] ? (a - adj) : (a + adj);
                fo = {rb == 8'h00, f[FLAG_N], 1'b0, dc};
            end
            OP_CPL: begin
                rb = ~a;
                fo = {zin, 1'b1, 1'b1, cin};
            end
            OP_SCF: begin
                rb = a;
                wr = 1'b0;
                fo = {zin, 1'b0, 1'b0, 1'b1};
            end
            OP_CCF: begin
                rb = a;
                wr = 1'b0;
                fo = {zin, 1'b0, 1'b0, ~cin};
            end
            OP_RLC: begin
                rb = {v[6:0], v[7]};
                fo = {rb == 8'h00, 2'b00, v[7]};
            end
            OP_RRC: begin
                rb = {v[0], v[7:1]};
                fo = {rb == 8'h00, 2'b00, v[0]};
            end
            OP_RL: begin
                rb = {v[6:0], cin};
                fo = {rb == 8'h00, 2'b00, v[7]};
            end
            OP_RR: begin
                rb = {cin, v[7:1]};
                fo = {rb == 8'h00, 2'b00, v[0]};
            end
            OP_SLA: begin
                rb = {v[6:0], 1'b0};
                fo = {rb == 8'h00, 2'b00, v[7]};
            end
            OP_SRA: begin
                rb = {v[7], v[7:1]};
                fo = {rb == 8'h00, 2'b00, v[0]};
            end
            OP_SWAP: begin
                rb = {v[3:0], v[7:4]};
                fo = {rb == 8'h00, 3'b000};
            end
            OP_SRL: begin
                rb = {1'b0, v[7:1]};
                fo = {rb == 8'h00, 2'b00, v[0]};
            end
            OP_ADD16: begin
                rw = sum17[15:0];
                fo = {zin, 1'b0, sum13[12], sum17[16]};
            end
            OP_INC16: begin
                rw = i_in.wide_base + 16'd1;
            end
            OP_DEC16: begin
                rw = i_in.wide_base - 16'd1;
            end
            default: begin
                wr = 1'b0;
            end
        endcase

        o_out.result_byte = rb;
        o_out.result_wide = rw;
        o_out.flags_out   = fo;
        o_out.write_back  = wr;
    end

endmodule

// ===== hdl/cpu_alu_with_flags.sv =====
// Channel  | Direction | tdata (low bit up)                                  | tuser
// s_axis   | in        | acc, operand, wide_base, wide_addend, flags_in, pad | op
// m_axis   | out       | result_byte, result_wide, flags_out, pad            | write_back
//
// One item per cycle sustained while m_axis_tready stays high; an item passes the input and result registers.
// Input register feeds the ALU logic, which feeds the result register.
// Reset is synchronous, active low, and empties both registers.
// A stalled output holds its result; the input register still fills, so one
// more item is taken before s_axis_tready drops.
module cpu_alu_with_flags
    import calu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // acc[7:0], operand[15:8], wide_base[31:16], wide_addend[47:32], flags_in[51:48]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op[4:0]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // result_byte[7:0], result_wide[23:8], flags_out[27:24]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // write_back[0]
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    logic     r_in_vld;
    t_alu_in  r_in;
    logic     r_out_vld;
    t_alu_out r_out;
    t_alu_out n_out;
    t_alu_in  n_in;
    logic     out_load;
    logic     in_load;

    assign out_load      = !r_out_vld || m_axis_tready;
    assign in_load       = !r_in_vld || out_load;
    assign s_axis_tready = in_load;

    always_comb begin
        n_in.op          = t_op'(s_axis_tuser);
        n_in.acc         = s_axis_tdata[7:0];
        n_in.operand     = s_axis_tdata[15:8];
        n_in.wide_base   = s_axis_tdata[31:16];
        n_in.wide_addend = s_axis_tdata[47:32];
        n_in.flags_in    = s_axis_tdata[51:48];
    end

    calu_core u_core (
        .i_in  (r_in),
        .o_out (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_load) r_in_vld <= s_axis_tvalid;
            if (out_load) r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && s_axis_tvalid) r_in <= n_in;
        if (out_load && r_in_vld) r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'h0, r_out.flags_out, r_out.result_wide, r_out.result_byte};
    assign m_axis_tuser  = r_out.write_back;

endmodule

// ===== hdl/calu_checker.sv =====
module calu_checker
    import calu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tready,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic [OUT_USER_W-1:0] m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    a_wide_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[23:8] != 16'h0000) |->
            m_axis_tuser[0] && (m_axis_tdata[7:0] == 8'h00))
        else $error("wide result without write-back or with byte result");

endmodule

bind cpu_alu_with_flags calu_checker u_calu_checker (.*);

// ===== tb/tb_cpu_alu_with_flags.sv =====
module tb_cpu_alu_with_flags;
    import calu_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 1250;
    localparam int unsigned IDLE_PCT     = 19;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct {
        logic [4:0] op;
        t_alu_out   res;
    } t_alu_due;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    t_alu_due   alu_results_due[$];
    t_alu_due   due_head;
    t_alu_out   seen;
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    bit         tx_idle_en     = 1'b1;
    bit         rx_idle_en     = 1'b1;
    int         hold_off_req   = 0;
    int         hold_off_left  = 0;
    logic [7:0] byte_corners[8] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h0F, 8'hF0, 8'h01, 8'h99};

    cpu_alu_with_flags dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [3:0] flag_set(logic z, logic n, logic h, logic c);
        logic [3:0] f;
        f         = '0;
        f[FLAG_Z] = z;
        f[FLAG_N] = n;
        f[FLAG_H] = h;
        f[FLAG_C] = c;
        return f;
    endfunction

    function automatic t_alu_out alu_result_of(logic [4:0] op, logic [7:0] a, logic [7:0] v,
                                               logic [15:0] wb, logic [15:0] wa, logic [3:0] f);
        t_alu_out    r;
        logic        c;
        logic        cin;
        logic        zin;
        logic        carry_daa;
        logic [8:0]  sum9;
        logic [16:0] sum17;
        logic [7:0]  adj;
        logic [7:0]  rb;
        c   = f[FLAG_C];
        zin = f[FLAG_Z];
        rb  = '0;
        r.result_byte = '0;
        r.result_wide = '0;
        r.flags_out   = f;
        r.write_back  = 1'b1;
        case (op)
            OP_ADD, OP_ADC: begin
                cin  = (op == OP_ADC) ? c : 1'b0;
                sum9 = {1'b0, a} + {1'b0, v} + {8'b0, cin};
                rb   = sum9[7:0];
                r.flags_out = flag_set(rb == 8'h00, 1'b0,
                    ({1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'b0, cin}) > 5'h0F, sum9[8]);
            end
            OP_SUB, OP_SBC, OP_CP: begin
                cin = (op == OP_SBC) ? c : 1'b0;
                rb  = a - v - {7'b0, cin};
                r.flags_out = flag_set(rb == 8'h00, 1'b1,
                    {1'b0, a[3:0]} < ({1'b0, v[3:0]} + {4'b0, cin}),
                    {1'b0, a} < ({1'b0, v} + {8'b0, cin}));
                if (op == OP_CP) r.write_back = 1'b0;
            end
            OP_AND: begin
                rb = a & v;
                r.flags_out = flag_set(rb == 8'h00, 1'b0, 1'b1, 1'b0);
            end
            OP_XOR: begin
                rb = a ^ v;
                r.flags_out = flag_set(rb == 8'h00, 1'b0, 1'b0, 1'b0);
            end
            OP_OR: begin
                rb = a | v;
                r.flags_out = flag_set(rb == 8'h00, 1'b0, 1'b0, 1'b0);
            end
            OP_INC: begin
                rb = v + 8'd1;
                r.flags_out = flag_set(rb == 8'h00, 1'b0, v[3:0] == 4'hF, c);
            end
            OP_DEC: begin
                rb = v - 8'd1;
                r.flags_out = flag_set(rb == 8'h00, 1'b1, v[3:0] == 4'h0, c);
            end
            OP_RLCA: begin
                rb = {a[6:0], a[7]};
                r.flags_out = flag_set(1'b0, 1'b0, 1'b0, a[7]);
            end
            OP_RRCA: begin
                rb = {a[0], a[7:1]};
                r.flags_out = flag_set(1'b0, 1'b0, 1'b0, a[0]);
            end
            OP_RLA: begin
                rb = {a[6:0], c};
                r.flags_out = flag_set(1'b0, 1'b0, 1'b0, a[7]);
            end
            OP_RRA: begin
                rb = {c, a[7:1]};
                r.flags_out = flag_set(1'b0, 1'b0, 1'b0, a[0]);
            end
            OP_DAA: begin
                adj = '0;
                if (f[FLAG_N]) begin
                    if (f[FLAG_H]) adj = adj + 8'h06;
                    if (c) adj = adj + 8'h60;
                    rb = a - adj;
                    r.flags_out = flag_set(rb == 8'h00, 1'b1, 1'b0, c);
                end else begin
                    carry_daa = 1'b0;
                    if (f[FLAG_H] || a[3:0] > 4'h9) adj = adj + 8'h06;
                    if (c || a > 8'h99) begin
                        adj       = adj + 8'h60;
                        carry_daa = 1'b1;
                    end
                    rb = a + adj;
                    r.flags_out = flag_set(rb == 8'h00, 1'b0, 1'b0, carry_daa);
                end
            end
            OP_CPL: begin
                rb = ~a;
                r.flags_out = flag_set(zin, 1'b1, 1'b1, c);
            end
            OP_SCF: begin
                rb = a;
                r.write_back = 1'b0;
                r.flags_out  = flag_set(zin, 1'b0, 1'b0, 1'b1);
            end
            OP_CCF: begin
                rb = a;
                r.write_back = 1'b0;
                r.flags_out  = flag_set(zin, 1'b0, 1'b0, ~c);
            end
            OP_RLC: begin
                rb = {v[6:0], v[7]};
                r.flags_out = flag_set(rb == 8'h00, 1'b0, 1'b0, v[7]);
            end
            OP_RRC: begin
                rb = {v[0], v[7:1]};
                r.flags_out = flag_set(rb == 8'h00, 1'b0, 1'b0, v[0]);
            end
            OP_RL: begin
                rb = {v[6:0], c};
                r.flags_out = flag_set(rb == 8'h00, 1'b0, 1'b0, v[7]);
            end
            OP_RR: begin
                rb = {c, v[7:1]};
                r.flags_out = flag_set(rb == 8'h00, 1'b0, 1'b0, v[0]);
            end
            OP_SLA: begin
                rb = {v[6:0], 1'b0};
                r.flags_out = flag_set(rb == 8'h00, 1'b0, 1'b0, v[7]);
            end
            OP_SRA: begin
                rb = {v[7], v[7:1]};
                r.flags_out = flag_set(rb == 8'h00, 1'b0, 1'b0, v[0]);
            end
            OP_SWAP: begin
                rb = {v[3:0], v[7:4]};
                r.flags_out = flag_set(rb == 8'h00, 1'b0, 1'b0, 1'b0);
            end
            OP_SRL: begin
                rb = {1'b0, v[7:1]};
                r.flags_out = flag_set(rb == 8'h00, 1'b0, 1'b0, v[0]);
            end
            OP_ADD16: begin
                sum17 = {1'b0, wb} + {1'b0, wa};
                r.result_wide = sum17[15:0];
                r.flags_out = flag_set(zin, 1'b0,
                    ({1'b0, wb[11:0]} + {1'b0, wa[11:0]}) > 13'h0FFF, sum17[16]);
            end
            OP_INC16: r.result_wide = wb + 16'd1;
            OP_DEC16: r.result_wide = wb - 16'd1;
            default:  r.write_back = 1'b0;
        endcase
        r.result_byte = rb;
        return r;
    endfunction

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(3) == 0) return byte_corners[$urandom_range(7)];
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(5))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return {4'($urandom), 12'hFFF};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(logic [4:0] op, logic [7:0] a, logic [7:0] v,
                             logic [15:0] wb, logic [15:0] wa, logic [3:0] f);
        t_alu_due due;
        if (tx_idle_en) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, f, wa, wb, v, a};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        due.op  = op;
        due.res = alu_result_of(op, a, v, wb, wa, f);
        alu_results_due.push_back(due);
    endtask

    task automatic test_each_op();
        for (int k = 0; k < 32; k++) begin
            send_item(5'(k), byte_corners[k % 8], byte_corners[(k + 3) % 8],
                      {byte_corners[(k + 1) % 8], byte_corners[(k + 5) % 8]},
                      {byte_corners[(k + 6) % 8], byte_corners[(k + 2) % 8]}, 4'(k));
        end
    endtask

    task automatic test_corner_cases();
        send_item(OP_ADD,   8'hFF, 8'h01, 16'h0000, 16'h0000, 4'h0);
        send_item(OP_ADC,   8'h0F, 8'h00, 16'h0000, 16'h0000,
                  flag_set(1'b0, 1'b0, 1'b0, 1'b1));
        send_item(OP_SBC,   8'h00, 8'hFF, 16'h0000, 16'h0000,
                  flag_set(1'b0, 1'b0, 1'b0, 1'b1));
        send_item(OP_SBC,   8'h10, 8'h0F, 16'h0000, 16'h0000,
                  flag_set(1'b0, 1'b0, 1'b0, 1'b1));
        send_item(OP_CP,    8'h42, 8'h42, 16'h0000, 16'h0000, 4'h0);
        send_item(OP_DAA,   8'h9A, 8'h00, 16'h0000, 16'h0000, 4'h0);
        send_item(OP_DAA,   8'h00, 8'h00, 16'h0000, 16'h0000,
                  flag_set(1'b0, 1'b1, 1'b1, 1'b1));
        send_item(OP_INC,   8'h00, 8'hFF, 16'h0000, 16'h0000,
                  flag_set(1'b0, 1'b0, 1'b0, 1'b1));
        send_item(OP_DEC,   8'h00, 8'h00, 16'h0000, 16'h0000, 4'h0);
        send_item(OP_ADD16, 8'h00, 8'h00, 16'hFFFF, 16'h0001,
                  flag_set(1'b1, 1'b1, 1'b0, 1'b0));
        send_item(OP_ADD16, 8'h00, 8'h00, 16'h0FFF, 16'h0001, 4'h0);
        send_item(OP_INC16, 8'h00, 8'h00, 16'hFFFF, 16'h0000, 4'hF);
        send_item(OP_DEC16, 8'h00, 8'h00, 16'h0000, 16'hFFFF, 4'h5);
    endtask

    task automatic test_random_mix();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            tx_idle_en = !(n >= 500 && n < 800);
            rx_idle_en = tx_idle_en;
            send_item(5'($urandom_range(31)), pick_byte(), pick_byte(), pick_word(),
                      pick_word(), 4'($urandom));
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_output_stall();
        tx_idle_en   = 1'b0;
        hold_off_req = 300;
        for (int n = 0; n < 30; n++) begin
            send_item(5'($urandom_range(28)), pick_byte(), pick_byte(), pick_word(),
                      pick_word(), 4'($urandom));
        end
        tx_idle_en = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (hold_off_req != 0) begin
            hold_off_left = hold_off_req;
            hold_off_req  = 0;
        end
        if (hold_off_left != 0) begin
            hold_off_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(99) < IDLE_PCT) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.result_byte = m_axis_tdata[7:0];
            seen.result_wide = m_axis_tdata[23:8];
            seen.flags_out   = m_axis_tdata[27:24];
            seen.write_back  = m_axis_tuser[0];
            if (alu_results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer: byte %h wide %h flags %b wb %b",
                             seen.result_byte, seen.result_wide, seen.flags_out,
                             seen.write_back);
            end else begin
                due_head = alu_results_due.pop_front();
                if (seen != due_head.res) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("op %0d: exp %h %h %b %b, got %h %h %b %b",
                                 due_head.op, due_head.res.result_byte,
                                 due_head.res.result_wide, due_head.res.flags_out,
                                 due_head.res.write_back, seen.result_byte,
                                 seen.result_wide, seen.flags_out, seen.write_back);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_cpu_alu_with_flags: errors");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_each_op();
        test_corner_cases();
        test_random_mix();
        test_output_stall();
        s_axis_tvalid <= 1'b0;
        while (alu_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && alu_results_due.size() == 0) begin
            $display("tb_cpu_alu_with_flags: clean");
        end else begin
            $display("tb_cpu_alu_with_flags: errors");
        end
        $finish;
    end

endmodule
